### sv/pcpa_pkg.sv
// shared constants, codes and control structs of the per-cpu page allocator
// no dependencies; imported by pcpa_ctrl, pcpa_dp and the top level

package pcpa_pkg;

    localparam int NUM_CPUS   = 8;
    localparam int PAGE_SLOTS = 4096;
    localparam int PAGE_BYTES = 4096;

    localparam int ADDR_W    = 40;
    localparam int CPU_W     = 3;
    localparam int CFG_IDX_W = 8;
    localparam int PB_SHIFT  = $clog2(PAGE_BYTES);
    localparam int SLOT_W    = $clog2(PAGE_SLOTS);
    localparam int HEAD_W    = SLOT_W + 1;
    localparam int CPU_IDX_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int SLOTW_W   = ADDR_W + 1 - PB_SHIFT;

    localparam logic [HEAD_W-1:0] EMPTY_MARK = HEAD_W'(PAGE_SLOTS);

    localparam logic [CFG_IDX_W-1:0] REG_REGION_LOW  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_REGION_HIGH = CFG_IDX_W'(1);

    localparam logic MODE_FREE  = 1'b0;
    localparam logic MODE_ALLOC = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_BAD   = 2'd2
    } status_t;

    typedef struct packed {
        logic accept;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_block;
    } dp_status_t;

endpackage

### sv/pcpa_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies

module pcpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/pcpa_ctrl.sv
// request sequencer of the page allocator: accept, then commit one result
// depends on pcpa_pkg

module pcpa_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  pcpa_pkg::dp_status_t  dp_status,
    output pcpa_pkg::ctrl_cmd_t   cmd
);

    import pcpa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.accept = 1'b0;
        cmd.commit = 1'b0;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // hold while the output register still carries an untaken result
                if (!dp_status.out_block)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### sv/pcpa_dp.sv
// allocator datapath: region registers, per-cpu heads, link ram, result register
// depends on pcpa_pkg and pcpa_ram

module pcpa_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pcpa_pkg::ctrl_cmd_t               cmd,
    output pcpa_pkg::dp_status_t              dp_status,
    input  logic                              cfg_we,
    input  logic [pcpa_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [pcpa_pkg::ADDR_W-1:0]       cfg_wdata,
    input  logic                              in_mode,
    input  logic [pcpa_pkg::CPU_W-1:0]        in_cpu,
    input  logic [pcpa_pkg::ADDR_W-1:0]       in_page_addr,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [pcpa_pkg::ADDR_W-1:0]       out_alloc_addr,
    output logic [1:0]                        out_status
);

    import pcpa_pkg::*;

    // configuration
    logic [ADDR_W-1:0] region_low_reg;
    logic [ADDR_W-1:0] region_high_reg;
    logic [ADDR_W:0]   slot_base_reg;
    logic [ADDR_W:0]   base_round;

    // list heads
    logic [HEAD_W-1:0] head_reg [NUM_CPUS];

    // request registers
    logic                 req_mode_reg;
    logic [ADDR_W-1:0]    req_pa_reg;
    logic [CPU_IDX_W-1:0] sel_idx_reg;
    logic                 sel_found_reg;
    logic [HEAD_W-1:0]    sel_head_reg;

    // result register
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [ADDR_W-1:0] out_addr_reg;
    logic [1:0]        out_status_reg;

    // accept-side selection
    logic                 own_hit;
    logic [CPU_IDX_W-1:0] own_idx;
    logic                 any_nonempty;
    logic [CPU_IDX_W-1:0] low_idx;
    logic                 own_nonempty;
    logic [CPU_IDX_W-1:0] sel_idx;
    logic                 sel_found;
    logic [HEAD_W-1:0]    sel_head;

    // commit-side logic
    logic [ADDR_W:0]      pa_diff;
    logic [SLOTW_W-1:0]   slot_wide;
    logic                 free_ok;
    logic [HEAD_W-1:0]    link_rd;
    logic [HEAD_W-1:0]    next_head;
    logic [ADDR_W:0]      pop_addr;
    logic                 ram_we;
    logic                 ram_re;

    assign base_round = {1'b0, cfg_wdata} + (ADDR_W+1)'(PAGE_BYTES - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_low_reg  <= '0;
            region_high_reg <= '0;
            slot_base_reg   <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_idx == REG_REGION_LOW)
            begin
                region_low_reg <= cfg_wdata;
                slot_base_reg  <= {base_round[ADDR_W:PB_SHIFT], {PB_SHIFT{1'b0}}};
            end
            else if (cfg_idx == REG_REGION_HIGH)
            begin
                region_high_reg <= cfg_wdata;
            end
        end
    end

    always_comb
    begin
        own_hit      = 1'b0;
        own_idx      = '0;
        any_nonempty = 1'b0;
        low_idx      = '0;
        for (int i = NUM_CPUS - 1; i >= 0; i--)
        begin
            if (int'(in_cpu) == i)
            begin
                own_hit = 1'b1;
                own_idx = CPU_IDX_W'(i);
            end
            if (head_reg[i] != EMPTY_MARK)
            begin
                any_nonempty = 1'b1;
                low_idx      = CPU_IDX_W'(i);
            end
        end
        own_nonempty = own_hit && (head_reg[own_idx] != EMPTY_MARK);
        // a free always targets its own list; an allocate steals only when its own is empty
        if ((in_mode == MODE_FREE) || own_nonempty)
        begin
            sel_idx = own_idx;
        end
        else
        begin
            sel_idx = low_idx;
        end
        sel_found = (in_mode == MODE_FREE) ? own_hit : (own_nonempty || any_nonempty);
        sel_head  = head_reg[sel_idx];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_mode_reg  <= in_mode;
            req_pa_reg    <= in_page_addr;
            sel_idx_reg   <= sel_idx;
            sel_found_reg <= sel_found;
            sel_head_reg  <= sel_head;
        end
    end

    // free address checks; an aligned address at or above region_low is at or above the base
    assign pa_diff   = {1'b0, req_pa_reg} - slot_base_reg;
    assign slot_wide = pa_diff[ADDR_W:PB_SHIFT];
    assign free_ok   = sel_found_reg
                    && (req_pa_reg[PB_SHIFT-1:0] == '0)
                    && (req_pa_reg >= region_low_reg)
                    && (req_pa_reg < region_high_reg)
                    && (slot_wide < SLOTW_W'(PAGE_SLOTS));

    assign next_head = (link_rd > EMPTY_MARK) ? EMPTY_MARK : link_rd;
    assign pop_addr  = slot_base_reg
                     + (ADDR_W+1)'({sel_head_reg[SLOT_W-1:0], {PB_SHIFT{1'b0}}});

    assign ram_re = cmd.accept && (in_mode == MODE_ALLOC) && sel_found;
    assign ram_we = cmd.commit && (req_mode_reg == MODE_FREE) && free_ok;

    pcpa_ram #(
        .WIDTH (HEAD_W),
        .DEPTH (PAGE_SLOTS)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_wide[SLOT_W-1:0]),
        .wdata (sel_head_reg),
        .re    (ram_re),
        .raddr (sel_head[SLOT_W-1:0]),
        .rdata (link_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CPUS; i++)
            begin
                head_reg[i] <= EMPTY_MARK;
            end
        end
        else if (cmd.commit && sel_found_reg)
        begin
            if (req_mode_reg == MODE_ALLOC)
            begin
                head_reg[sel_idx_reg] <= next_head;
            end
            else if (free_ok)
            begin
                head_reg[sel_idx_reg] <= {1'b0, slot_wide[SLOT_W-1:0]};
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            if (req_mode_reg == MODE_FREE)
            begin
                out_addr_reg   <= '0;
                out_status_reg <= free_ok ? ST_OK : ST_BAD;
            end
            else if (sel_found_reg)
            begin
                out_addr_reg   <= pop_addr[ADDR_W-1:0];
                out_status_reg <= ST_OK;
            end
            else
            begin
                out_addr_reg   <= '0;
                out_status_reg <= ST_EMPTY;
            end
        end
    end

    assign dp_status.out_block = out_valid_reg && !out_ready;
    assign out_valid      = out_valid_reg;
    assign out_alloc_addr = out_addr_reg;
    assign out_status     = out_status_reg;

endmodule

### sv/per_cpu_page_free_list_allocator.sv
// Per-cpu page free-list allocator. Each cpu owns a lifo list of page slots kept as a head
// register plus a shared link ram; a free (tuser 0) pushes the page onto the requesting cpu's
// list, an allocate (tuser 1) pops the own list or else the lowest-numbered non-empty list.
// Bad free addresses come back with status 2, an allocate with every list empty with status 1.
// A request selects the list and starts the synchronous link ram read, then updates the head
// and loads the result register, stalling while the previous result is untaken. The next
// request is taken while that result waits on the master side. Link ram is not cleared; no
// clearing pass is needed. The user must write region registers through the cfg channel only
// while idle, which the block does not enforce. Top level; depends on pcpa_pkg, pcpa_ctrl, pcpa_dp, pcpa_ram

module per_cpu_page_free_list_allocator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pcpa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pcpa_pkg::ADDR_W-1:0]    cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [47:0]                    s_axis_tdata,   // cpu[2:0], page_addr[42:3], zero pad
    input  logic                           s_axis_tuser,   // mode
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [39:0]                    m_axis_tdata,   // alloc_addr[39:0]
    output logic [1:0]                     m_axis_tuser    // status[1:0]
);

    import pcpa_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    assign cfg_ready = 1'b1;

    pcpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    pcpa_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .dp_status      (dp_status),
        .cfg_we         (cfg_valid),
        .cfg_idx        (cfg_index),
        .cfg_wdata      (cfg_data),
        .in_mode        (s_axis_tuser),
        .in_cpu         (s_axis_tdata[CPU_W-1:0]),
        .in_page_addr   (s_axis_tdata[CPU_W+ADDR_W-1:CPU_W]),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_alloc_addr (m_axis_tdata),
        .out_status     (m_axis_tuser)
    );

endmodule
